// ===== rtl/tts_pkg.sv =====
// shared types and codes for the timer table scheduler
`timescale 1ns / 1ps
package tts_pkg;
	localparam int unsigned ID_W = 32;
	localparam int unsigned MAX_FIRE = 16;

	typedef enum logic [1:0] {
		OP_ARM     = 2'd0,
		OP_CANCEL  = 2'd1,
		OP_SERVICE = 2'd2,
		OP_BAD     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ARMED     = 3'd0,
		ST_FULL      = 3'd1,
		ST_CANCELLED = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FIRED     = 3'd4,
		ST_NONE_DUE  = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [47:0] deadline;
		logic [47:0] period;
		logic [31:0] timer_id;
		logic [47:0] time_now;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] result_id;
		logic        last;
		logic        has_deadline;
		logic [47:0] earliest_deadline;
	} out_word_t;

	// request to the remainder unit and its answer
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

// ===== rtl/tts_rem.sv =====
// iterative restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
module tts_rem #(
	parameter int unsigned W = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output tts_pkg::div_ctl_t ctl,
	output logic [W-1:0] rem
);
	localparam int unsigned CW = $clog2(W + 1);
	logic [W-1:0] num_q;
	logic [W-1:0] den_q;
	logic [W:0]   acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	assign trial = {acc_q[W-1:0], num_q[W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			acc_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[W-2:0], 1'b0};
			acc_q <= diff[W] ? trial : diff;
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
	assign rem       = acc_q[W-1:0];
endmodule

// ===== rtl/timer_table_scheduler.sv =====
// timer table scheduler top level: slot table, sequencer, remainder unit
// arm and cancel: slot scan, decide, min pass, result word; a bad op is dropped, no word
// service: a scan per fired timer, a re-arm per periodic one, a remainder division when
//   missed periods are skipped, a closing scan unless the fire cap is hit, then the min
// one input word at a time; in_stall high after acceptance until last word taken
// reset clears valid bits, id counter and sequencer; slot payload is left as is
`timescale 1ns / 1ps
module timer_table_scheduler #(
	parameter int unsigned SLOTS = 16,
	parameter int unsigned TIME_BITS = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tts_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output tts_pkg::out_word_t  out_data
);
	localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned NW = $clog2(SLOTS + 1);
	localparam int unsigned FW = $clog2(tts_pkg::MAX_FIRE + 1);
	localparam int unsigned XW = $clog2(tts_pkg::MAX_FIRE);
	localparam logic [TIME_BITS-1:0] TMAX = '1;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_REARM, S_DIVWAIT, S_REALIGN, S_MIN, S_OUT
	} state_t;

	// slot storage: valid bits in flops, payload in memories
	logic [SLOTS-1:0]     valid_q;
	logic [SLOTS-1:0]     due_q;
	logic [31:0]          id_mem  [SLOTS];
	logic [TIME_BITS-1:0] dl_mem  [SLOTS];
	logic [TIME_BITS-1:0] per_mem [SLOTS];
	// ids of the timers fired by one service, sent once the step is complete
	logic [31:0]          fid_mem [tts_pkg::MAX_FIRE];

	state_t               state_q;
	logic [31:0]          id_counter_q;
	logic [1:0]           op_q;
	logic [TIME_BITS-1:0] in_dl_q;
	logic [TIME_BITS-1:0] in_per_q;
	logic [31:0]          in_tid_q;
	logic [TIME_BITS-1:0] now_q;
	logic [NW-1:0]        idx_q;
	logic [SW-1:0]        sidx;
	// scan results
	logic                 found_q;
	logic [SW-1:0]        pick_q;
	logic [TIME_BITS-1:0] pick_dl_q;
	logic [31:0]          pick_id_q;
	logic [TIME_BITS-1:0] pick_per_q;
	logic [FW-1:0]        nfired_q;
	logic [FW-1:0]        oidx_q;   // next fired id to send
	logic                 any_q;
	logic [TIME_BITS-1:0] best_q;
	logic [2:0]           status_q;
	logic [31:0]          rid_q;
	logic                 last_q;
	logic                 more_q;   // fire cap not reached, scan again after this fire
	logic                 div_start;
	logic [TIME_BITS-1:0] rem;
	tts_pkg::div_ctl_t    div_ctl;
	logic [TIME_BITS:0]   sum;
	logic [TIME_BITS-1:0] nx;
	logic                 better;

	assign sidx = idx_q[SW-1:0];

	// fires-before compare against the current pick
	always_comb begin
		if (dl_mem[sidx] != pick_dl_q)
			better = dl_mem[sidx] < pick_dl_q;
		else
			better = (id_mem[sidx] - id_counter_q) < (pick_id_q - id_counter_q);
	end

	// shared saturating adder: rearm and realign paths
	always_comb begin
		if (state_q == S_REALIGN)
			sum = {1'b0, now_q - rem} + {1'b0, pick_per_q};
		else
			sum = {1'b0, pick_dl_q} + {1'b0, pick_per_q};
		nx = sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
	end

	assign div_start = (state_q == S_REARM) && (nx <= now_q);

	tts_rem #(.W(TIME_BITS)) u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (now_q - pick_dl_q),
		.den    (pick_per_q),
		.ctl    (div_ctl),
		.rem    (rem)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data.status            = status_q;
	assign out_data.result_id         = rid_q;
	assign out_data.last              = last_q;
	assign out_data.has_deadline      = any_q;
	assign out_data.earliest_deadline = any_q ? best_q : '0;

	always_ff @(posedge clk) begin
		// arm payload goes to the first free slot the scan meets
		if (state_q == S_SCAN && op_q == tts_pkg::OP_ARM && !found_q && !valid_q[sidx]) begin
			id_mem[sidx]  <= id_counter_q;
			dl_mem[sidx]  <= in_dl_q;
			per_mem[sidx] <= in_per_q;
		end
		if (state_q == S_DECIDE && op_q == tts_pkg::OP_SERVICE && found_q)
			fid_mem[nfired_q[XW-1:0]] <= pick_id_q;
		if (state_q == S_REARM && !(nx <= now_q))
			dl_mem[pick_q] <= nx;
		if (state_q == S_REALIGN)
			dl_mem[pick_q] <= nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			due_q        <= '0;
			id_counter_q <= '0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			nfired_q     <= '0;
			oidx_q       <= '0;
			any_q        <= 1'b0;
			more_q       <= 1'b0;
			last_q       <= 1'b0;
			status_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= in_data.operation;
						in_dl_q  <= in_data.deadline[TIME_BITS-1:0];
						in_per_q <= in_data.period[TIME_BITS-1:0];
						in_tid_q <= in_data.timer_id;
						now_q    <= in_data.time_now[TIME_BITS-1:0];
						idx_q    <= '0;
						found_q  <= 1'b0;
						nfired_q <= '0;
						if (in_data.operation != tts_pkg::OP_BAD)
							state_q <= S_SCAN;
						if (in_data.operation == tts_pkg::OP_SERVICE)
							for (int i = 0; i < SLOTS; i++)
								due_q[i] <= valid_q[i] && dl_mem[i] <= in_data.time_now[TIME_BITS-1:0];
					end
				end
				S_SCAN: begin
					case (op_q)
						tts_pkg::OP_ARM: begin
							if (!found_q && !valid_q[sidx]) begin
								found_q       <= 1'b1;
								valid_q[sidx] <= 1'b1;
							end
						end
						tts_pkg::OP_CANCEL: begin
							if (valid_q[sidx] && id_mem[sidx] == in_tid_q) begin
								found_q       <= 1'b1;
								valid_q[sidx] <= 1'b0;
							end
						end
						default: begin
							if (due_q[sidx] && valid_q[sidx] && (!found_q || better)) begin
								found_q    <= 1'b1;
								pick_q     <= sidx;
								pick_dl_q  <= dl_mem[sidx];
								pick_id_q  <= id_mem[sidx];
								pick_per_q <= per_mem[sidx];
							end
						end
					endcase
					if (idx_q == NW'(SLOTS - 1))
						state_q <= S_DECIDE;
					else
						idx_q <= idx_q + 1'b1;
				end
				S_DECIDE: begin
					case (op_q)
						tts_pkg::OP_ARM: begin
							status_q <= found_q ? tts_pkg::ST_ARMED : tts_pkg::ST_FULL;
							rid_q    <= found_q ? id_counter_q : '0;
							if (found_q)
								id_counter_q <= id_counter_q + 1'b1;
							state_q <= S_MIN;
						end
						tts_pkg::OP_CANCEL: begin
							status_q <= found_q ? tts_pkg::ST_CANCELLED : tts_pkg::ST_NOT_FOUND;
							rid_q    <= in_tid_q;
							state_q  <= S_MIN;
						end
						default: begin
							if (found_q) begin
								// id kept in fid_mem, words go out after the min
								due_q[pick_q] <= 1'b0;
								nfired_q      <= nfired_q + 1'b1;
								more_q        <= (nfired_q != FW'(tts_pkg::MAX_FIRE - 1));
								if (pick_per_q == '0) begin
									valid_q[pick_q] <= 1'b0;
									state_q <= (nfired_q != FW'(tts_pkg::MAX_FIRE - 1)) ?
										S_SCAN : S_MIN;
								end else begin
									state_q <= S_REARM;
								end
							end else begin
								// nothing more due: close the step
								if (nfired_q == '0) begin
									status_q <= tts_pkg::ST_NONE_DUE;
									rid_q    <= '0;
								end
								state_q <= S_MIN;
							end
						end
					endcase
					idx_q   <= '0;
					found_q <= 1'b0;
					any_q   <= 1'b0;
				end
				S_REARM: begin
					if (nx <= now_q)
						state_q <= S_DIVWAIT;
					else
						state_q <= more_q ? S_SCAN : S_MIN;
				end
				S_DIVWAIT: begin
					if (div_ctl.done)
						state_q <= S_REALIGN;
				end
				S_REALIGN: begin
					state_q <= more_q ? S_SCAN : S_MIN;
				end
				S_MIN: begin
					// earliest live deadline, one slot per cycle
					if (valid_q[sidx] && (!any_q || dl_mem[sidx] < best_q)) begin
						best_q <= dl_mem[sidx];
						any_q  <= 1'b1;
					end
					if (idx_q == NW'(SLOTS - 1)) begin
						state_q <= S_OUT;
						oidx_q  <= FW'(1);
						if (op_q == tts_pkg::OP_SERVICE && nfired_q != '0) begin
							status_q <= tts_pkg::ST_FIRED;
							rid_q    <= fid_mem[0];
							last_q   <= (nfired_q == FW'(1));
						end else begin
							last_q <= 1'b1;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						if (!last_q) begin
							// next fired id, in firing order
							rid_q  <= fid_mem[oidx_q[XW-1:0]];
							last_q <= (oidx_q == nfired_q - FW'(1));
							oidx_q <= oidx_q + FW'(1);
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !out_valid) else $error("output while idle");
	a_fire_cap: assert property (@(posedge clk) disable iff (!arst_n)
		nfired_q <= FW'(tts_pkg::MAX_FIRE)) else $error("fire count overflow");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.done |-> (state_q == S_DIVWAIT)) else $error("stray remainder");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open during output");
`endif
endmodule

// ===== bench/tb.sv =====
// self-checking bench for the timer table scheduler
`timescale 1ns / 1ps
module tb;
	localparam int NSLOT = 16;
	localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
	localparam int LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	tts_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	tts_pkg::out_word_t out_data;

	always #4 clk = ~clk;

	timer_table_scheduler u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// predictor copy of the timer table
	logic        tbl_live [NSLOT];
	logic [31:0] tbl_id [NSLOT];
	logic [47:0] tbl_due [NSLOT];
	logic [47:0] tbl_per [NSLOT];
	logic [31:0] next_id;

	tts_pkg::in_word_t  pending_words [$];
	tts_pkg::out_word_t expected_words [$];
	int mismatches = 0;
	int cycles = 0;

	function automatic logic [47:0] sat_sum(logic [47:0] a, logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? TMAX : s[47:0];
	endfunction

	// true if slot a fires ahead of slot b
	function automatic bit ahead(int a, int b);
		if (tbl_due[a] != tbl_due[b])
			return tbl_due[a] < tbl_due[b];
		return (tbl_id[a] - next_id) < (tbl_id[b] - next_id);
	endfunction

	// work out the result words of one accepted word
	task automatic predict_word(tts_pkg::in_word_t w);
		tts_pkg::out_word_t res [$];
		tts_pkg::out_word_t r;
		bit due [NSLOT];
		bit found, any;
		logic [47:0] best, f, p, nx, base;
		int pick;
		r = '0;
		case (tts_pkg::op_t'(w.operation))
			tts_pkg::OP_ARM: begin
				r.status = tts_pkg::ST_FULL;
				for (int i = 0; i < NSLOT; i++) begin
					if (!tbl_live[i]) begin
						tbl_live[i] = 1'b1;
						tbl_id[i] = next_id;
						tbl_due[i] = w.deadline;
						tbl_per[i] = w.period;
						r.status = tts_pkg::ST_ARMED;
						r.result_id = next_id;
						next_id++;
						break;
					end
				end
				res = {res, r};
			end
			tts_pkg::OP_CANCEL: begin
				found = 1'b0;
				for (int i = 0; i < NSLOT; i++) begin
					if (tbl_live[i] && tbl_id[i] == w.timer_id) begin
						tbl_live[i] = 1'b0;
						found = 1'b1;
					end
				end
				r.status = found ? tts_pkg::ST_CANCELLED : tts_pkg::ST_NOT_FOUND;
				r.result_id = w.timer_id;
				res = {res, r};
			end
			tts_pkg::OP_SERVICE: begin
				for (int i = 0; i < NSLOT; i++)
					due[i] = tbl_live[i] && tbl_due[i] <= w.time_now;
				while (res.size() < tts_pkg::MAX_FIRE) begin
					pick = -1;
					for (int i = 0; i < NSLOT; i++) begin
						if (due[i] && tbl_live[i] && (pick < 0 || ahead(i, pick)))
							pick = i;
					end
					if (pick < 0)
						break;
					due[pick] = 1'b0;
					r = '0;
					r.status = tts_pkg::ST_FIRED;
					r.result_id = tbl_id[pick];
					res = {res, r};
					if (tbl_per[pick] == 0) begin
						tbl_live[pick] = 1'b0;
					end else begin
						f = tbl_due[pick];
						p = tbl_per[pick];
						nx = sat_sum(f, p);
						// skip missed periods
						if (nx <= w.time_now) begin
							base = w.time_now - ((w.time_now - f) % p);
							nx = sat_sum(base, p);
						end
						tbl_due[pick] = nx;
					end
				end
				if (res.size() == 0) begin
					r = '0;
					r.status = tts_pkg::ST_NONE_DUE;
					res = {res, r};
				end
			end
			default: ;
		endcase
		any = 1'b0;
		best = '0;
		for (int i = 0; i < NSLOT; i++) begin
			if (tbl_live[i]) begin
				if (!any || tbl_due[i] < best)
					best = tbl_due[i];
				any = 1'b1;
			end
		end
		foreach (res[k]) begin
			res[k].last = (k == res.size() - 1);
			res[k].has_deadline = any;
			res[k].earliest_deadline = best;
			expected_words = {expected_words, res[k]};
		end
	endtask

	function automatic logic [47:0] rand48();
		return {$urandom(), $urandom()};
	endfunction

	function automatic tts_pkg::in_word_t make_word(tts_pkg::op_t op, logic [47:0] dl,
			logic [47:0] per, logic [31:0] id, logic [47:0] now);
		tts_pkg::in_word_t w;
		w.operation = op;
		w.deadline = dl;
		w.period = per;
		w.timer_id = id;
		w.time_now = now;
		return w;
	endfunction

	// driver: one word at a time with a random gap before each
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else if (in_valid && !in_stall) begin
			predict_word(in_data);
			void'(pending_words.pop_front());
			if (pending_words.size() > 0 && $urandom_range(0, 3) != 0) begin
				send_gap <= $urandom_range(0, 19);
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				in_data <= pending_words[0];
			end else begin
				in_valid <= 1'b0;
			end
		end else if (!in_valid && pending_words.size() > 0) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else begin
				in_valid <= 1'b1;
				in_data <= pending_words[0];
			end
		end
	end

	// monitor: compare each taken word with the oldest expectation
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		tts_pkg::out_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word %h", out_data);
				end else begin
					want = expected_words.pop_front();
					if (out_data !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: st %0d/%0d id %h/%h last %b/%b has %b/%b dl %h/%h",
								want.status, out_data.status, want.result_id, out_data.result_id,
								want.last, out_data.last, want.has_deadline,
								out_data.has_deadline, want.earliest_deadline,
								out_data.earliest_deadline);
					end
				end
				// some stretches without back pressure
				stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		logic [47:0] t;
		logic [31:0] id;
		int r;
		int narm;
		for (int i = 0; i < NSLOT; i++) begin
			tbl_live[i] = 1'b0;
			tbl_id[i] = '0;
			tbl_due[i] = '0;
			tbl_per[i] = '0;
		end
		next_id = '0;
		// directed: extremes, full table, cancels, overflow, ties, missed periods
		pending_words = {pending_words, make_word(tts_pkg::OP_SERVICE, 0, 0, 0, 0)};
		pending_words = {pending_words, make_word(tts_pkg::OP_CANCEL, 0, 0, 32'hFFFF_FFFF, 0)};
		pending_words = {pending_words, make_word(tts_pkg::OP_ARM, TMAX, 0, 0, 0)};
		pending_words = {pending_words, make_word(tts_pkg::OP_ARM, 48'd100, 48'd10, 0, 0)};
		pending_words = {pending_words, make_word(tts_pkg::OP_ARM, 48'd100, 0, 0, 0)};
		pending_words = {pending_words, make_word(tts_pkg::OP_ARM, TMAX - 5, TMAX, 0, 0)};
		pending_words = {pending_words, make_word(tts_pkg::OP_ARM, 0, 48'd7, 0, 0)};
		for (int i = 0; i < 12; i++)
			pending_words = {pending_words,
				make_word(tts_pkg::OP_ARM, 48'd50 + i, 48'd3, 0, 0)};
		pending_words = {pending_words,
			make_word(tts_pkg::OP_BAD, TMAX, TMAX, 32'hFFFF_FFFF, TMAX)};
		pending_words = {pending_words, make_word(tts_pkg::OP_CANCEL, 0, 0, 32'd2, 0)};
		pending_words = {pending_words, make_word(tts_pkg::OP_SERVICE, 0, 0, 0, 48'd1000)};
		pending_words = {pending_words, make_word(tts_pkg::OP_SERVICE, 0, 0, 0, TMAX - 1)};
		pending_words = {pending_words, make_word(tts_pkg::OP_SERVICE, 0, 0, 0, TMAX)};
		pending_words = {pending_words, make_word(tts_pkg::OP_CANCEL, 0, 0, 32'd1, 0)};
		narm = 17;
		// random: mostly well-formed traffic around a moving clock
		t = 48'd0;
		for (int n = 0; n < 385; n++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				narm++;
				if ($urandom_range(0, 15) == 0)
					pending_words = {pending_words,
						make_word(tts_pkg::OP_ARM, rand48(), rand48(), 0, 0)};
				else
					pending_words = {pending_words,
						make_word(tts_pkg::OP_ARM, t + $urandom_range(0, 300),
						($urandom_range(0, 2) == 0) ? 48'd0 : 48'($urandom_range(1, 120)),
						0, 0)};
			end else if (r < 55) begin
				// mostly ids that were handed out, some that never were
				if ($urandom_range(0, 3) != 0)
					id = $urandom_range(0, narm);
				else
					id = $urandom();
				pending_words = {pending_words,
					make_word(tts_pkg::OP_CANCEL, rand48(), rand48(), id, rand48())};
			end else if (r < 97) begin
				t = t + $urandom_range(0, 150);
				pending_words = {pending_words,
					make_word(tts_pkg::OP_SERVICE, rand48(), rand48(), $urandom(), t)};
			end else begin
				pending_words = {pending_words,
					make_word(tts_pkg::OP_BAD, rand48(), rand48(), $urandom(), rand48())};
			end
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_words.size() != 0 || expected_words.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end
endmodule
